>>> rtl/deq_pkg.sv
`timescale 1ns / 1ps
// Shared constants, command and status codes, and the memory operation type of the deque.
package deq_pkg;

	localparam int CMD_W   = 3;
	localparam int DATA_W  = 32;
	localparam int COUNT_W = 11;
	localparam int STAT_W  = 2;

	// Command codes carried by each input item.
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
	localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 3'd5;
	localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd6;

	// Status codes returned with each result item.
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_DATA  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

	// What the pointer logic asks of the entry memory for one item.
	typedef struct packed {
		logic              we;
		logic              re;
		logic [STAT_W-1:0] status;
	} mem_op_t;

endpackage

>>> rtl/deq_ptr.sv
`timescale 1ns / 1ps
// Head and count registers of the deque, with the entry address and status for each command.
module deq_ptr #(
	parameter int DEPTH = 1024,
	parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  logic [deq_pkg::CMD_W-1:0] cmd,
	output deq_pkg::mem_op_t        op,
	output logic [IW-1:0]           addr,
	output logic [CW-1:0]           count_nxt
);

	logic [IW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] head_nxt;
	logic [IW-1:0] head_inc;
	logic [IW-1:0] head_dec;
	logic [IW-1:0] back_wr;
	logic [IW-1:0] back_rd;
	logic [CW-1:0] count_m1;
	logic          empty;
	logic          full;

	// Modular add of two indexes that are each below DEPTH.
	function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
		logic [IW:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= (IW+1)'(DEPTH)) begin
			sum = sum - (IW+1)'(DEPTH);
		end
		return sum[IW-1:0];
	endfunction

	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(DEPTH));
	assign count_m1 = count_q - CW'(1);
	assign head_inc = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + IW'(1);
	assign head_dec = (head_q == '0) ? IW'(DEPTH - 1) : head_q - IW'(1);
	// The count is below DEPTH whenever these are used, so its low bits suffice.
	assign back_wr  = wrap_add(head_q, count_q[IW-1:0]);
	assign back_rd  = wrap_add(head_q, count_m1[IW-1:0]);

	always_comb begin
		op.we     = 1'b0;
		op.re     = 1'b0;
		op.status = deq_pkg::ST_OK;
		addr      = head_q;
		head_nxt  = head_q;
		count_nxt = count_q;
		case (cmd) inside
			deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
				if (full) begin
					op.status = deq_pkg::ST_FULL;
				end else begin
					op.we     = 1'b1;
					count_nxt = count_q + CW'(1);
					if (cmd == deq_pkg::CMD_PUSH_FRONT) begin
						addr     = head_dec;
						head_nxt = head_dec;
					end else begin
						addr = back_wr;
					end
				end
			end
			deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK,
			deq_pkg::CMD_PEEK_FRONT, deq_pkg::CMD_PEEK_BACK: begin
				if (empty) begin
					op.status = deq_pkg::ST_EMPTY;
				end else begin
					op.re     = 1'b1;
					op.status = deq_pkg::ST_DATA;
					if (cmd == deq_pkg::CMD_POP_FRONT || cmd == deq_pkg::CMD_PEEK_FRONT) begin
						addr = head_q;
					end else begin
						addr = back_rd;
					end
					if (cmd == deq_pkg::CMD_POP_FRONT) begin
						head_nxt  = head_inc;
						count_nxt = count_m1;
					end else if (cmd == deq_pkg::CMD_POP_BACK) begin
						count_nxt = count_m1;
					end
				end
			end
			deq_pkg::CMD_CLEAR: begin
				head_nxt  = '0;
				count_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (advance) begin
			head_q  <= head_nxt;
			count_q <= count_nxt;
		end
	end

endmodule

>>> rtl/double_ended_queue_unit.sv
`timescale 1ns / 1ps
// Top level of the double-ended queue: entry memory, result pipeline and output register.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  in      | input     | in_valid / in_ready   | cmd (3), value (32 signed)
//  out     | output    | out_valid / out_ready | status (2), data (32 signed),
//          |           |                       | count (11)
//
// One item is accepted per cycle while the output side keeps taking results. An item's
// result passes two registers before it is offered at the output: the entry memory's
// registered read port makes up the first stage, the output register the second.
// Reset clears the head, the count and all valid flags; the entry memory is not
// cleared, since an entry is only ever read after a push has filled it.
// When out_ready is low the output register holds and one more result may wait
// in the read stage; once both are full, in_ready drops until the output moves.
module double_ended_queue_unit #(
	parameter int DEPTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [deq_pkg::CMD_W-1:0]         cmd,
	input  logic signed [deq_pkg::DATA_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [deq_pkg::STAT_W-1:0]        status,
	output logic signed [deq_pkg::DATA_W-1:0] data,
	output logic [deq_pkg::COUNT_W-1:0]       count
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic                         accept;
	logic                         s1_move;
	deq_pkg::mem_op_t             op;
	logic [IW-1:0]                addr;
	logic [CW-1:0]                count_nxt;

	// Entry memory: one write or one read per accepted item, read data registered.
	logic [deq_pkg::DATA_W-1:0]   mem [DEPTH];

	// Read stage: the memory's output register and the item's side information.
	logic                         valid_s1;
	logic [deq_pkg::STAT_W-1:0]   status_s1;
	logic [deq_pkg::COUNT_W-1:0]  count_s1;
	logic [deq_pkg::DATA_W-1:0]   rdata_s1;

	// Output register.
	logic                         out_valid_q;
	logic [deq_pkg::STAT_W-1:0]   status_q;
	logic [deq_pkg::DATA_W-1:0]   data_q;
	logic [deq_pkg::COUNT_W-1:0]  count_q;

	// The read stage moves on whenever the output register is empty or being emptied.
	assign s1_move  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Pointer updates take effect at the accepting edge, so the next item already
	// sees the new head and count. Memory writes land at the same edge, which means
	// a read by a following item always finds the word in place.
	deq_ptr #(
		.DEPTH (DEPTH),
		.IW    (IW),
		.CW    (CW)
	) u_ptr (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (accept),
		.cmd       (cmd),
		.op        (op),
		.addr      (addr),
		.count_nxt (count_nxt)
	);

	always_ff @(posedge clk) begin
		if (accept && op.we) begin
			mem[addr] <= value;
		end
		if (accept && op.re) begin
			rdata_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	// The count is reported modulo 2**11, as the result field is 11 bits wide.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= op.status;
			count_s1  <= deq_pkg::COUNT_W'(count_nxt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The data word is only shown for a successful pop or peek; it reads as zero otherwise.
	always_ff @(posedge clk) begin
		if (s1_move) begin
			status_q <= status_s1;
			count_q  <= count_s1;
			data_q   <= (status_s1 == deq_pkg::ST_DATA) ? rdata_s1 : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign data      = data_q;
	assign count     = count_q;

endmodule

>>> rtl/deq_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the double-ended queue, bound to the top level.
module deq_chk #(
	parameter int DEPTH = 1024
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [deq_pkg::STAT_W-1:0]        status,
	input logic signed [deq_pkg::DATA_W-1:0] data,
	input logic [deq_pkg::COUNT_W-1:0]       count
);

	// A result without a popped or peeked word carries a zero data field.
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != deq_pkg::ST_DATA |-> data == '0)
		else $error("data field not zero on a result without data");

	// An empty error can only arise when no entries are held.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == deq_pkg::ST_EMPTY |-> count == '0)
		else $error("empty error reported with a nonzero count");

	// A full error leaves the deque holding exactly DEPTH entries.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == deq_pkg::ST_FULL |-> count == deq_pkg::COUNT_W'(DEPTH))
		else $error("full error reported with a count other than DEPTH");

	// A stalled result holds its fields.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(status) && $stable(data) && $stable(count))
		else $error("stalled result changed");

	// The input is only held off while a result is waiting at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |-> out_valid)
		else $error("input stalled with no result waiting");

endmodule

bind double_ended_queue_unit deq_chk #(.DEPTH(DEPTH)) u_deq_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.data      (data),
	.count     (count)
);
